// ===== rtl/trapezoid_velocity_profile_assert.svh =====
// Assertion macros for the trapezoid velocity profile block.
// Used by the port-level checker; needs no other file.
`ifndef TRAPEZOID_VELOCITY_PROFILE_ASSERT_SVH
`define TRAPEZOID_VELOCITY_PROFILE_ASSERT_SVH

// same-cycle implication, skipped while reset is high
`define TVP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tvp assertion failed");

// next-cycle implication, skipped while reset is high
`define TVP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tvp assertion failed");

// next-cycle implication that also holds through reset
`define TVP_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("tvp assertion failed");

`endif

// ===== rtl/tvp_pkg.sv =====
// Shared types and constants of the trapezoid velocity profile block.
// No dependencies; imported by the register file, the top level and the testbench.
package tvp_pkg;

   // register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_MODE     = 3'd0;
   localparam logic [2:0] REG_PEAK     = 3'd1;
   localparam logic [2:0] REG_INITIAL  = 3'd2;
   localparam logic [2:0] REG_FINAL    = 3'd3;
   localparam logic [2:0] REG_ACCEL    = 3'd4;
   localparam logic [2:0] REG_LENGTH   = 3'd5;
   localparam logic [2:0] REG_FLOOR    = 3'd6;

   // mode codes
   localparam logic [1:0] MODE_STRAIGHT = 2'd0;
   localparam logic [1:0] MODE_STOP     = 2'd1;
   localparam logic [1:0] MODE_FREE     = 2'd2;

   localparam int unsigned VEL_W = 13;
   localparam int unsigned ACC_W = 16;
   localparam int unsigned LEN_W = 30;
   localparam int unsigned CSR_AW = 5;

   // um per mm, as a multiplier operand
   localparam logic signed [17:0] UM_PER_MM = 18'sd1000;

   localparam logic [ACC_W-1:0] ACCEL_RESET = 16'd1000;

   typedef struct packed {
      logic [1:0]       mode;
      logic [VEL_W-1:0] peak;
      logic [VEL_W-1:0] initial_v;
      logic [VEL_W-1:0] final_v;
      logic [ACC_W-1:0] accel;
      logic [LEN_W-1:0] length;
      logic [VEL_W-1:0] floor_v;
   } tvp_cfg_type;

endpackage

// ===== rtl/tvp_csr.sv =====
// Configuration register file of the trapezoid velocity profile block.
// APB-style write/read port; depends on tvp_pkg.
module tvp_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [tvp_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready,
   output tvp_pkg::tvp_cfg_type      cfg
);
   import tvp_pkg::*;

   tvp_cfg_type cfg_ff;
   logic        wr_en;
   logic [2:0]  idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx        = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode      <= MODE_STOP;
         cfg_ff.peak      <= '0;
         cfg_ff.initial_v <= '0;
         cfg_ff.final_v   <= '0;
         cfg_ff.accel     <= ACCEL_RESET;
         cfg_ff.length    <= '0;
         cfg_ff.floor_v   <= '0;
      end else if (wr_en) begin
         unique case (idx)
            REG_MODE:    cfg_ff.mode      <= csr_pwdata[1:0];
            REG_PEAK:    cfg_ff.peak      <= csr_pwdata[VEL_W-1:0];
            REG_INITIAL: cfg_ff.initial_v <= csr_pwdata[VEL_W-1:0];
            REG_FINAL:   cfg_ff.final_v   <= csr_pwdata[VEL_W-1:0];
            REG_ACCEL:   cfg_ff.accel     <= csr_pwdata[ACC_W-1:0];
            REG_LENGTH:  cfg_ff.length    <= csr_pwdata[LEN_W-1:0];
            REG_FLOOR:   cfg_ff.floor_v   <= csr_pwdata[VEL_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (idx)
         REG_MODE:    csr_prdata = {30'd0, cfg_ff.mode};
         REG_PEAK:    csr_prdata = {19'd0, cfg_ff.peak};
         REG_INITIAL: csr_prdata = {19'd0, cfg_ff.initial_v};
         REG_FINAL:   csr_prdata = {19'd0, cfg_ff.final_v};
         REG_ACCEL:   csr_prdata = {16'd0, cfg_ff.accel};
         REG_LENGTH:  csr_prdata = {2'd0, cfg_ff.length};
         REG_FLOOR:   csr_prdata = {19'd0, cfg_ff.floor_v};
         default:     csr_prdata = 32'd0;
      endcase
   end

endmodule

// ===== rtl/tvp_mul.sv =====
// Shared signed multiplier of the trapezoid velocity profile block.
// 34 x 18 bits, product registered; no dependencies.
module tvp_mul (
   input  logic               clock,
   input  logic signed [33:0] op_a,
   input  logic signed [17:0] op_b,
   output logic signed [51:0] prod
);

   logic signed [51:0] prod_ff;

   // one product per cycle
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/trapezoid_velocity_profile.sv =====
// Top level of the trapezoid velocity profile block: sequencer, state, stream ports.
// Depends on tvp_pkg, tvp_csr and tvp_mul.
//
//   channel   dir  ports                          payload
//   req       in   req_tvalid/tready/tdata        travelled (32 b signed)
//   rsp       out  rsp_tvalid/tready/tdata/tuser  velocity_out, accel_out, done_res
//   csr       in   csr_psel/penable/pwrite/...    7 registers at 4*index
//
// Straight mode: the shared multiplier does seven products one after another in steps
// ST_PK to ST_LA, then ST_PH picks the phase and ST_FIN loads the result. Stop and free mode go to ST_FIN.
// A new item is taken in the cycle after the result is loaded, even while it waits.
// Synchronous reset clears state and the result slot; a stalled result holds the
// final step until the slot frees.
module trapezoid_velocity_profile (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [31:0]                req_tdata,   // [31:0] travelled
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [55:0]                rsp_tdata,   // [31:0] velocity_out, [48:32] accel_out
   output logic                       rsp_tuser,   // [0] done_res
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [tvp_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   import tvp_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PK, ST_V0, ST_V1, ST_AN, ST_DN, ST_SA, ST_LA, ST_PH, ST_FIN
   } state_type;

   // times 1000 as shift and subtract: 1024 - 16 - 8
   function automatic logic [22:0] mul1000(input logic [12:0] x);
      logic [22:0] w;
      begin
         w = {x, 10'b0} - {6'b0, x, 4'b0} - {7'b0, x, 3'b0};
         return w;
      end
   endfunction

   tvp_cfg_type cfg;

   state_type          state_ff;
   logic signed [31:0] s_ff;
   logic signed [33:0] ls_ff;
   logic [25:0]        pk2_ff;
   logic signed [26:0] accd_ff;
   logic signed [26:0] decd_ff;
   logic signed [37:0] accn_ff;
   logic signed [37:0] decn_ff;
   logic               cmp_acc_ff;
   logic               straight_ff;
   logic signed [31:0] vacc_ff;
   logic signed [16:0] accel_ff;
   logic [12:0]        limit_ff;
   logic               done_ff;
   logic               rsp_tvalid_ff;
   logic [31:0]        rsp_vel_ff;
   logic [16:0]        rsp_acc_ff;
   logic               rsp_done_ff;

   logic signed [33:0] op_a;
   logic signed [17:0] op_b;
   logic signed [51:0] prod;
   logic signed [17:0] two_a;
   logic signed [16:0] a_pos;
   logic signed [51:0] accn_ext;
   logic signed [51:0] decn_ext;
   logic signed [32:0] fl_ext;
   logic signed [32:0] vsum;
   logic signed [32:0] vsat;
   logic signed [32:0] vmag;
   logic signed [32:0] lim_ext;
   logic signed [31:0] vnext;
   logic               slot_free;
   logic               accept;

   tvp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tvp_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   assign two_a     = $signed({1'b0, cfg.accel, 1'b0});
   assign a_pos     = $signed({1'b0, cfg.accel});
   assign accn_ext  = {{14{accn_ff[37]}}, accn_ff};
   assign decn_ext  = {{14{decn_ff[37]}}, decn_ff};
   assign fl_ext    = $signed({10'b0, mul1000(cfg.floor_v)});
   assign slot_free = !rsp_tvalid_ff || rsp_tready;
   assign accept    = req_tvalid && req_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {7'b0, rsp_acc_ff, rsp_vel_ff};
   assign rsp_tuser  = rsp_done_ff;

   // multiplier operand select per step
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         ST_PK: begin
            op_a = $signed({21'b0, cfg.peak});
            op_b = $signed({5'b0, cfg.peak});
         end
         ST_V0: begin
            op_a = $signed({21'b0, cfg.initial_v});
            op_b = $signed({5'b0, cfg.initial_v});
         end
         ST_V1: begin
            op_a = $signed({21'b0, cfg.final_v});
            op_b = $signed({5'b0, cfg.final_v});
         end
         ST_AN: begin
            op_a = {{7{accd_ff[26]}}, accd_ff};
            op_b = UM_PER_MM;
         end
         ST_DN: begin
            op_a = {{7{decd_ff[26]}}, decd_ff};
            op_b = UM_PER_MM;
         end
         ST_SA: begin
            op_a = {{2{s_ff[31]}}, s_ff};
            op_b = two_a;
         end
         ST_LA: begin
            op_a = ls_ff;
            op_b = two_a;
         end
         default: ;
      endcase
   end

   // velocity integration: add step, saturate to 32 bits, clamp to limit
   always_comb begin
      vsum    = {vacc_ff[31], vacc_ff} + {{16{accel_ff[16]}}, accel_ff};
      if (vsum > 33'sh07FFFFFFF)
         vsat = 33'sh07FFFFFFF;
      else if (vsum < -33'sh080000000)
         vsat = -33'sh080000000;
      else
         vsat = vsum;
      vmag    = vsat[32] ? -vsat : vsat;
      lim_ext = $signed({10'b0, mul1000(limit_ff)});
      vnext   = (vmag > lim_ext) ? lim_ext[31:0] : vsat[31:0];
   end

   // sequencer, profile state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         vacc_ff       <= '0;
         accel_ff      <= '0;
         limit_ff      <= '0;
         done_ff       <= 1'b0;
         straight_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // result slot: filled by the last step, emptied by a transfer
         if (state_ff == ST_FIN && slot_free)
            rsp_tvalid_ff <= 1'b1;
         else if (rsp_tvalid_ff && rsp_tready)
            rsp_tvalid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  s_ff        <= $signed(req_tdata);
                  straight_ff <= (cfg.mode == MODE_STRAIGHT);
                  done_ff     <= (cfg.mode != MODE_STRAIGHT) && (cfg.mode != MODE_STOP);
                  state_ff    <= (cfg.mode == MODE_STRAIGHT) ? ST_PK : ST_FIN;
               end
            end
            ST_PK: begin
               ls_ff    <= $signed({4'b0, cfg.length}) - {{2{s_ff[31]}}, s_ff};
               state_ff <= ST_V0;
            end
            ST_V0: begin
               pk2_ff   <= prod[25:0];
               state_ff <= ST_V1;
            end
            ST_V1: begin
               accd_ff  <= $signed({1'b0, pk2_ff}) - prod[26:0];
               state_ff <= ST_AN;
            end
            ST_AN: begin
               decd_ff  <= $signed({1'b0, pk2_ff}) - prod[26:0];
               state_ff <= ST_DN;
            end
            ST_DN: begin
               accn_ff  <= prod[37:0];
               state_ff <= ST_SA;
            end
            ST_SA: begin
               decn_ff  <= prod[37:0];
               state_ff <= ST_LA;
            end
            ST_LA: begin
               cmp_acc_ff <= (accn_ext > prod);
               state_ff   <= ST_PH;
            end
            ST_PH: begin
               // phase choice: accelerate or cruise, decelerate or snap up to the floor, done
               if (cmp_acc_ff || (prod > decn_ext)) begin
                  accel_ff <= a_pos;
                  limit_ff <= cfg.peak;
                  done_ff  <= 1'b0;
               end else if (ls_ff > 34'sd0) begin
                  done_ff <= 1'b0;
                  if ($signed({vacc_ff[31], vacc_ff}) < fl_ext) begin
                     accel_ff <= '0;
                     vacc_ff  <= fl_ext[31:0];
                  end else begin
                     accel_ff <= -a_pos;
                  end
               end else begin
                  accel_ff <= '0;
                  vacc_ff  <= {9'b0, mul1000(cfg.final_v)};
                  done_ff  <= 1'b1;
               end
               state_ff <= ST_FIN;
            end
            ST_FIN: begin
               if (slot_free) begin
                  rsp_acc_ff    <= accel_ff;
                  rsp_done_ff   <= done_ff;
                  if (straight_ff) begin
                     vacc_ff    <= vnext;
                     rsp_vel_ff <= vnext;
                  end else begin
                     rsp_vel_ff <= vacc_ff;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/tvp_checker.sv =====
// Port-level checker for the trapezoid velocity profile block, with its bind.
// Depends on trapezoid_velocity_profile_assert.svh.
`include "trapezoid_velocity_profile_assert.svh"

module tvp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tuser
);

   // a stalled result keeps its data
   `TVP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // reset empties the result slot
   `TVP_ASSERT_NXT_ALWAYS(a_rsp_reset, clock, reset, !rsp_tvalid)

   // an accepted item keeps the block busy in the next cycle
   `TVP_ASSERT_NXT(a_busy_after, clock, reset, req_tvalid && req_tready, !req_tready)

   // acceleration is 0 or +/- accel_rate, never the most negative code
   `TVP_ASSERT_IMP(a_accel_range, clock, reset, rsp_tvalid, rsp_tdata[48:32] != 17'h10000)

endmodule

bind trapezoid_velocity_profile tvp_checker u_tvp_checker (.*);

// ===== tb/sv/trapezoid_velocity_profile_tb.sv =====
// Self-checking testbench for the trapezoid velocity profile block.
// Needs tvp_pkg and the RTL of trapezoid_velocity_profile; holds its own profile predictor.
`timescale 1ns / 1ps

module trapezoid_velocity_profile_tb;
   import tvp_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int TICKS_PER_SECOND = 1000;
   localparam longint INT32_HI = 64'sh7FFF_FFFF;
   localparam longint INT32_LO = -64'sh8000_0000;
   localparam logic [29:0] LENGTH_MAX = 30'h3FFF_FFFF;

   // one expected result transfer
   typedef struct packed {
      logic [31:0] velocity;
      logic [16:0] accel;
      logic        done;
   } setpoint_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata = '0;    // [31:0] travelled
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [55:0]       rsp_tdata;         // [31:0] velocity_out, [48:32] accel_out
   logic              rsp_tuser;         // [0] done_res
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   // register shadow, at reset values
   logic [1:0]  cfg_mode = MODE_STOP;
   logic [12:0] cfg_peak = '0;
   logic [12:0] cfg_initial = '0;
   logic [12:0] cfg_final = '0;
   logic [15:0] cfg_accel = ACCEL_RESET;
   logic [29:0] cfg_length = '0;
   logic [12:0] cfg_floor = '0;

   // predicted block state
   int          vel_acc = 0;
   int          accel_now = 0;
   logic [13:0] vel_limit = '0;

   setpoint_type pending_setpoints[$];
   int unsigned  mismatches = 0;
   bit           idling_on = 1'b1;
   int unsigned  rsp_stall_left = 0;
   int unsigned  rsp_hold_left = 0;

   trapezoid_velocity_profile dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result-side ready: long hold first, then random stall bursts
   always @(negedge clock) begin
      if (rsp_hold_left != 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else if (rsp_stall_left != 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left <= $urandom_range(0, 6);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      setpoint_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_setpoints.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h/%b",
                     $time, rsp_tdata, rsp_tuser);
            mismatches++;
         end else begin
            want = pending_setpoints.pop_front();
            if (rsp_tdata[31:0] !== want.velocity) begin
               $display("%0t: velocity_out expected %h actual %h",
                        $time, want.velocity, rsp_tdata[31:0]);
               mismatches++;
            end
            if (rsp_tdata[48:32] !== want.accel) begin
               $display("%0t: accel_out expected %h actual %h",
                        $time, want.accel, rsp_tdata[48:32]);
               mismatches++;
            end
            if (rsp_tuser !== want.done) begin
               $display("%0t: done_res expected %b actual %b", $time, want.done, rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   // one control tick of the profile generator; queues the predicted result
   task automatic profile_step(input logic [31:0] travel);
      longint       s, a, two_a, pk, v0, v1, len, acc_num, dec_num, fl, v, lim, mag;
      logic         done_now;
      setpoint_type sp;
      s = longint'($signed(travel));
      done_now = 1'b0;
      if (cfg_mode == MODE_STRAIGHT) begin
         a = cfg_accel;
         two_a = 2 * a;
         pk = cfg_peak;
         v0 = cfg_initial;
         v1 = cfg_final;
         len = cfg_length;
         acc_num = (pk * pk - v0 * v0) * 1000;
         dec_num = (pk * pk - v1 * v1) * 1000;
         // phase choice by cross multiplication
         if (acc_num > s * two_a || (len - s) * two_a > dec_num) begin
            accel_now = int'(a);
            vel_limit = {1'b0, cfg_peak};
         end else if (len > s) begin
            fl = cfg_floor;
            fl = fl * 1000;
            accel_now = -int'(a);
            if (longint'(vel_acc) < fl) begin
               accel_now = 0;
               vel_acc = int'(fl);
            end
         end else begin
            accel_now = 0;
            vel_acc = int'(v1 * 1000);
            done_now = 1'b1;
         end
         // integrate, saturate, clamp magnitude to the limit
         v = longint'(vel_acc) + (longint'(accel_now) * 1000) / TICKS_PER_SECOND;
         lim = vel_limit;
         lim = lim * 1000;
         if (v > INT32_HI) v = INT32_HI;
         if (v < INT32_LO) v = INT32_LO;
         mag = (v < 0) ? -v : v;
         if (mag > lim) v = lim;
         vel_acc = int'(v);
      end else begin
         done_now = (cfg_mode != MODE_STOP);
      end
      sp.velocity = vel_acc;
      sp.accel = accel_now[16:0];
      sp.done = done_now;
      pending_setpoints.push_back(sp);
   endtask

   // offer one travelled distance; entered and left at a falling edge
   task automatic send_travel(input logic [31:0] travel);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= travel;
      do @(posedge clock); while (!req_tready);
      profile_step(travel);
      @(negedge clock);
   endtask

   // wait until every predicted result has been seen and the block is quiet
   task automatic drain_pending();
      req_tvalid <= 1'b0;
      while (pending_setpoints.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   // bus write, setup then access; leaves psel high for the next write
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_MODE:    cfg_mode = value[1:0];
         REG_PEAK:    cfg_peak = value[12:0];
         REG_INITIAL: cfg_initial = value[12:0];
         REG_FINAL:   cfg_final = value[12:0];
         REG_ACCEL:   cfg_accel = value[15:0];
         REG_LENGTH:  cfg_length = value[29:0];
         REG_FLOOR:   cfg_floor = value[12:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // full register set, written once the block is idle
   task automatic program_profile(input logic [1:0] md, input logic [12:0] pk,
                                  input logic [12:0] v0, input logic [12:0] v1,
                                  input logic [15:0] a, input logic [29:0] len,
                                  input logic [12:0] fl);
      drain_pending();
      write_reg(REG_MODE, 32'(md));
      write_reg(REG_PEAK, 32'(pk));
      write_reg(REG_INITIAL, 32'(v0));
      write_reg(REG_FINAL, 32'(v1));
      write_reg(REG_ACCEL, 32'(a));
      write_reg(REG_LENGTH, 32'(len));
      write_reg(REG_FLOOR, 32'(fl));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   function automatic logic [12:0] pick_speed();
      case ($urandom_range(0, 7))
         0: return 13'd0;
         1: return 13'h1FFF;
         default: return 13'($urandom_range(0, 8191));
      endcase
   endfunction

   // one move: a profile sized to its own ramps, then distances that walk past the end
   task automatic run_move(input int unsigned ticks);
      logic [1:0]  md;
      logic [12:0] pk, v0, v1, fl;
      logic [15:0] a;
      logic [29:0] len;
      longint      d_acc, d_dec, span, pos, stride;
      md = MODE_STRAIGHT;
      case ($urandom_range(0, 11))
         0: md = MODE_STOP;
         1: md = MODE_FREE;
         2: md = MODE_UNUSED;
         default: ;
      endcase
      pk = pick_speed();
      v0 = ($urandom_range(0, 2) == 0) ? pick_speed() : 13'($urandom_range(0, pk));
      v1 = ($urandom_range(0, 2) == 0) ? pick_speed() : 13'($urandom_range(0, pk));
      fl = ($urandom_range(0, 3) == 0) ? pick_speed() : 13'($urandom_range(0, 300));
      case ($urandom_range(0, 9))
         0: a = 16'd0;
         1: a = 16'hFFFF;
         2: a = 16'($urandom_range(1, 65535));
         default: a = 16'($urandom_range(200, 20000));
      endcase
      d_acc = 0;
      d_dec = 0;
      if (a != 0) begin
         d_acc = (longint'(pk) * longint'(pk) - longint'(v0) * longint'(v0)) * 1000
                 / (2 * longint'(a));
         d_dec = (longint'(pk) * longint'(pk) - longint'(v1) * longint'(v1)) * 1000
                 / (2 * longint'(a));
      end
      if (d_acc < 0) d_acc = 0;
      if (d_dec < 0) d_dec = 0;
      span = d_acc + d_dec + longint'($urandom_range(0, 2000000));
      if ($urandom_range(0, 3) == 0) span = longint'($urandom_range(0, 32'(LENGTH_MAX)));
      if (span > longint'(LENGTH_MAX)) span = LENGTH_MAX;
      len = span[29:0];
      program_profile(md, pk, v0, v1, a, len, fl);

      pos = ($urandom_range(0, 4) == 0) ? -longint'($urandom_range(0, 5000)) : 0;
      stride = span / (ticks > 6 ? ticks - 6 : 1) + 1;
      repeat (ticks) begin
         // mostly the walk, now and then a stray reading
         if ($urandom_range(0, 9) == 0) begin
            send_travel($urandom);
         end else begin
            send_travel(pos[31:0]);
            pos = pos + stride * $urandom_range(70, 130) / 100;
         end
      end
   endtask

   // reset leaves stop mode: outputs hold at zero, done low
   task automatic test_reset_state();
      send_travel(32'd0);
      send_travel(32'h7FFF_FFFF);
      send_travel(32'h8000_0000);
   endtask

   // free mode and the spare mode code only report done
   task automatic test_free_modes();
      program_profile(MODE_FREE, 13'd500, 13'd0, 13'd0, 16'd1000, 30'd100000, 13'd0);
      send_travel(32'd0);
      send_travel(32'hFFFF_FFFF);
      program_profile(MODE_UNUSED, 13'd500, 13'd0, 13'd0, 16'd1000, 30'd100000, 13'd0);
      send_travel(32'd50000);
      send_travel(32'h8000_0000);
   endtask

   // register extremes with extreme distances
   task automatic test_straight_extremes();
      program_profile(MODE_STRAIGHT, 13'h1FFF, 13'd0, 13'h1FFF, 16'hFFFF, LENGTH_MAX,
                      13'h1FFF);
      send_travel(32'h8000_0000);
      send_travel(32'd0);
      send_travel(32'h7FFF_FFFF);
      send_travel(32'(LENGTH_MAX));
      send_travel(32'(LENGTH_MAX) - 32'd1);
      send_travel(32'hFFFF_FFFF);
   endtask

   // zero acceleration: phases follow the sign of the distance numerators
   task automatic test_zero_accel();
      program_profile(MODE_STRAIGHT, 13'd100, 13'd100, 13'd200, 16'd0, 30'd5000, 13'd0);
      send_travel(32'd0);
      send_travel(32'd10000);
      program_profile(MODE_STRAIGHT, 13'd100, 13'd100, 13'd50, 16'd0, 30'd5000, 13'd0);
      send_travel(32'd0);
      send_travel(32'd6000);
   endtask

   // braking below the floor snaps to it, then brakes again
   task automatic test_floor_hold();
      program_profile(MODE_STRAIGHT, 13'd100, 13'd0, 13'd0, 16'd1000, 30'd1000000, 13'd50);
      send_travel(32'd0);
      send_travel(32'd1000000);
      send_travel(32'd999990);
      send_travel(32'd999990);
      send_travel(32'd999990);
   endtask

   task automatic test_random_moves();
      repeat (18) run_move($urandom_range(16, 32));
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_output_backpressure();
      drain_pending();
      @(posedge clock);
      rsp_hold_left = 300;
      @(negedge clock);
      run_move(30);
   endtask

   task automatic test_unthrottled_moves();
      drain_pending();
      idling_on = 1'b0;
      repeat (4) run_move($urandom_range(16, 32));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_free_modes();
      test_straight_extremes();
      test_zero_accel();
      test_floor_hold();
      test_random_moves();
      test_output_backpressure();
      test_unthrottled_moves();

      req_tvalid <= 1'b0;
      while (pending_setpoints.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatches == 0 && pending_setpoints.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // run limit, far beyond the slowest correct run
   initial begin
      #4000000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== trapezoid_velocity_profile.f =====
+incdir+rtl
rtl/tvp_pkg.sv
rtl/tvp_csr.sv
rtl/tvp_mul.sv
rtl/trapezoid_velocity_profile.sv
rtl/tvp_checker.sv
tb/sv/trapezoid_velocity_profile_tb.sv
